### rtl/bpsc_pkg.sv
`default_nettype none

package bpsc_pkg;

   localparam int CHANNELS_DEFAULT = 2;
   localparam int POS_W            = 5;

   // register indexes on the csr port
   localparam logic [1:0] CSR_PWM_STEP  = 2'd0;
   localparam logic [1:0] CSR_POSTSCALE = 2'd1;
   localparam logic [1:0] CSR_SETTLE    = 2'd2;
   localparam logic [1:0] CSR_PAUSE     = 2'd3;

   localparam logic [6:0]  PWM_STEP_RESET  = 7'd5;
   localparam logic [7:0]  POSTSCALE_RESET = 8'd32;
   localparam logic [7:0]  SETTLE_RESET    = 8'd1;
   localparam logic [15:0] PAUSE_RESET     = 16'd500;

   localparam logic [1:0] OP_NONE    = 2'd0;
   localparam logic [1:0] OP_STOP    = 2'd1;
   localparam logic [1:0] OP_SET_ONE = 2'd2;
   localparam logic [1:0] OP_SET_TWO = 2'd3;

   // sequencer phase within one channel
   localparam logic [1:0] PH_HALT    = 2'd0;
   localparam logic [1:0] PH_WAIT    = 2'd1;
   localparam logic [1:0] PH_START   = 2'd2;
   localparam logic [1:0] PH_MEASURE = 2'd3;

   localparam logic [6:0] PWM_TOP   = 7'd100;
   localparam logic [6:0] SPEED_MAX = 7'd100;
   localparam logic [6:0] CAP_FULL  = 7'd70;
   localparam logic [6:0] CAP_BASE  = 7'd30;
   localparam logic [6:0] CAP_KNEE  = 7'd10;

   typedef struct packed {
      logic [1:0]        opcode;
      logic signed [7:0] speed_arg;
      logic              adc_done;
      logic [6:0]        adc_value;
   } req_type;

   typedef struct packed {
      logic       gate_one;
      logic       gate_two;
      logic       adc_start;
      logic       adc_channel;
      logic [6:0] measured_one;
      logic [6:0] measured_two;
      logic [6:0] drive_one;
      logic [6:0] drive_two;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  pwm_step;
      logic [7:0]  postscale_count;
      logic [7:0]  settle_steps;
      logic [15:0] pause_steps;
   } cfg_type;

endpackage

`default_nettype wire

### rtl/backemf_pwm_speed_controller_core.sv
// A request beat is held in the input register, then in the output register, from which
// it shows on the response port.
// Throughput: one beat per cycle; input and output registers keep both sides moving
// while rsp_ready is high, and the input register absorbs one beat of stall.
// Reset (synchronous, active high) empties both registers, loads the csr defaults
// and returns the sequencer to the halt step of channel one with all powers at zero.
`default_nettype none

module backemf_pwm_speed_controller_core #(
   parameter int CHANNELS = bpsc_pkg::CHANNELS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire bpsc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output bpsc_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_wdata
);
   import bpsc_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   cfg_type cfg_ff;
   rsp_type result;
   logic    move;

   assign move         = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || move;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !move);
   assign rsp_valid_in = move || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   bpsc_engine #(
      .CHANNELS (CHANNELS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (move),
      .item   (in_data_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (move) begin
         rsp_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pwm_step        <= PWM_STEP_RESET;
         cfg_ff.postscale_count <= POSTSCALE_RESET;
         cfg_ff.settle_steps    <= SETTLE_RESET;
         cfg_ff.pause_steps     <= PAUSE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PWM_STEP:  cfg_ff.pwm_step        <= csr_wdata[6:0];
            CSR_POSTSCALE: cfg_ff.postscale_count <= csr_wdata[7:0];
            CSR_SETTLE:    cfg_ff.settle_steps    <= csr_wdata[7:0];
            CSR_PAUSE:     cfg_ff.pause_steps     <= csr_wdata;
            default:       cfg_ff.pause_steps     <= cfg_ff.pause_steps;
         endcase
      end
   end

endmodule

`default_nettype wire

### rtl/bpsc_measure.sv
`default_nettype none

module bpsc_measure (
   input  wire logic [6:0]        raw,
   input  wire logic [6:0]        speed,
   input  wire logic signed [7:0] accel,
   input  wire logic signed [7:0] target,
   input  wire logic [6:0]        saved_power,
   output logic [6:0]             speed_new,
   output logic signed [7:0]      accel_new,
   output logic [6:0]             power_new
);
   import bpsc_pkg::*;

   logic [6:0]         sample;
   logic [8:0]         q_sum;
   logic signed [7:0]  diff;
   logic signed [12:0] num;
   logic signed [12:0] num_adj;
   logic signed [12:0] quo;
   logic signed [8:0]  err_wide;
   logic signed [7:0]  err;
   logic signed [8:0]  err_adj;
   logic signed [7:0]  err_q;
   logic signed [9:0]  pw;
   logic [6:0]         cap;

   always_comb begin
      if (raw < 7'd2) begin
         sample = SPEED_MAX;
      end else if (raw > SPEED_MAX) begin
         sample = 7'd0;
      end else begin
         sample = SPEED_MAX - raw;
      end
   end

   // filter: s' = (3s + a)/4, accel from the exact quarter value
   assign q_sum     = 9'({speed, 1'b0}) + 9'(speed) + 9'(sample);
   assign diff      = $signed({1'b0, sample}) - $signed({1'b0, speed});
   assign num       = 13'(accel) * 13'sd12 + 13'(diff) * 13'sd10;
   assign num_adj   = num + ((num < 0) ? 13'sd15 : 13'sd0);
   assign quo       = num_adj >>> 4;
   assign speed_new = q_sum[8:2];

   always_comb begin
      if (quo > 13'sd127) begin
         accel_new = 8'sd127;
      end else if (quo < -13'sd128) begin
         accel_new = -8'sd128;
      end else begin
         accel_new = quo[7:0];
      end
   end

   assign err_wide = 9'(target) - $signed({2'b00, speed_new});
   assign err      = (err_wide < -9'sd128) ? -8'sd128 : err_wide[7:0];
   assign err_adj  = 9'(err) + ((err < 0) ? 9'sd3 : 9'sd0);
   assign err_q    = 8'(err_adj >>> 2);
   assign cap      = (speed_new >= CAP_KNEE) ? CAP_FULL : CAP_BASE + {speed_new[4:0], 2'b00};

   always_comb begin
      pw = $signed({3'b000, saved_power});
      if (err > 0) begin
         if (accel_new <= err_q) begin
            pw = pw + 10'(err_q) + 10'sd1;
         end
      end else begin
         if (accel_new >= err_q) begin
            pw = pw + 10'(err_q) - 10'sd1;
         end
      end
      if (target == 8'sd0) begin
         power_new = 7'd0;
      end else if (pw > $signed({3'b000, cap})) begin
         power_new = cap;
      end else if (pw < 0) begin
         power_new = 7'd0;
      end else begin
         power_new = pw[6:0];
      end
   end

endmodule

`default_nettype wire

### rtl/bpsc_engine.sv
`default_nettype none

module bpsc_engine #(
   parameter int CHANNELS = bpsc_pkg::CHANNELS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire bpsc_pkg::req_type item,
   input  wire bpsc_pkg::cfg_type cfg,
   output bpsc_pkg::rsp_type      result
);
   import bpsc_pkg::*;

   localparam int SLOTS = (CHANNELS < 2) ? 2 : CHANNELS;
   localparam int CH_W  = $clog2(SLOTS);
   localparam logic [POS_W-1:0] PAUSE_POS = POS_W'(4 * CHANNELS);

   logic [6:0]        pwm_ff, pwm_in;
   logic [7:0]        prescale_ff, prescale_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              moved_ff, moved_in;
   logic [15:0]       timer_ff, timer_in;
   logic [6:0]        saved_ff, saved_in;
   logic [SLOTS-1:0]  enable_ff, enable_in;
   logic [SLOTS-1:0]  gate_ff, gate_in;
   logic [6:0]        power_ff [SLOTS];
   logic [6:0]        power_in [SLOTS];
   logic signed [7:0] target_ff [SLOTS];
   logic signed [7:0] target_in [SLOTS];
   logic [6:0]        speed_ff [SLOTS];
   logic [6:0]        speed_in [SLOTS];
   logic signed [7:0] accel_ff [SLOTS];
   logic signed [7:0] accel_in [SLOTS];

   logic [7:0]        pwm_sum;
   logic [7:0]        prescale_inc;
   logic              step;
   logic [15:0]       timer_inc;
   logic [CH_W-1:0]   ch;
   logic [1:0]        phase;
   logic              start;
   logic [6:0]        m_speed;
   logic signed [7:0] m_accel;
   logic [6:0]        m_power;

   assign ch           = pos_ff[CH_W+1:2];
   assign phase        = pos_ff[1:0];
   assign pwm_sum      = {1'b0, pwm_ff} + {1'b0, cfg.pwm_step};
   assign prescale_inc = prescale_ff + 8'd1;
   assign step         = (prescale_inc == cfg.postscale_count);
   assign timer_inc    = (moved_ff ? 16'd0 : timer_ff) + 16'd1;

   bpsc_measure u_measure (
      .raw         (item.adc_value),
      .speed       (speed_ff[ch]),
      .accel       (accel_ff[ch]),
      .target      (target_in[ch]),
      .saved_power (saved_ff),
      .speed_new   (m_speed),
      .accel_new   (m_accel),
      .power_new   (m_power)
   );

   always_comb begin
      pwm_in      = (pwm_sum > {1'b0, PWM_TOP}) ? 7'd0 : pwm_sum[6:0];
      prescale_in = step ? 8'd0 : prescale_inc;
      pos_in      = pos_ff;
      timer_in    = timer_ff;
      saved_in    = saved_ff;
      enable_in   = enable_ff;
      gate_in     = gate_ff;
      start       = 1'b0;
      for (int c = 0; c < SLOTS; c++) begin
         power_in[c]  = power_ff[c];
         target_in[c] = target_ff[c];
         speed_in[c]  = speed_ff[c];
         accel_in[c]  = accel_ff[c];
      end

      // command first
      for (int c = 0; c < CHANNELS; c++) begin
         if (item.opcode == OP_STOP) begin
            target_in[c] = 8'sd0;
            power_in[c]  = 7'd0;
         end else if ((item.opcode == OP_SET_ONE && c == 0) ||
                      (item.opcode == OP_SET_TWO && c == 1)) begin
            target_in[c] = item.speed_arg;
         end
      end

      for (int c = 0; c < CHANNELS; c++) begin
         if (enable_ff[c]) begin
            gate_in[c] = (pwm_in < power_in[c]);
         end
      end

      if (step) begin
         if (pos_ff > PAUSE_POS) begin
            pos_in = '0;
         end else if (pos_ff == PAUSE_POS) begin
            timer_in = timer_inc;
            if (timer_inc >= cfg.pause_steps) begin
               pos_in = '0;
            end
         end else begin
            case (phase)
               PH_HALT: begin
                  saved_in      = power_in[ch];
                  enable_in[ch] = 1'b0;
                  power_in[ch]  = 7'd0;
                  gate_in[ch]   = 1'b0;
                  pos_in        = pos_ff + POS_W'(1);
               end
               PH_WAIT: begin
                  timer_in = timer_inc;
                  if (timer_inc > {8'd0, cfg.settle_steps}) begin
                     pos_in = pos_ff + POS_W'(1);
                  end
               end
               PH_START: begin
                  start  = 1'b1;
                  pos_in = pos_ff + POS_W'(1);
               end
               PH_MEASURE: begin
                  if (item.adc_done) begin
                     speed_in[ch]  = m_speed;
                     accel_in[ch]  = m_accel;
                     power_in[ch]  = m_power;
                     enable_in[ch] = 1'b1;
                     pos_in        = pos_ff + POS_W'(1);
                  end
               end
               default: begin
                  pos_in = pos_ff;
               end
            endcase
         end
      end
      moved_in = step ? (pos_in != pos_ff) : moved_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_ff      <= '0;
         prescale_ff <= '0;
         pos_ff      <= '0;
         moved_ff    <= 1'b1;
         timer_ff    <= '0;
         saved_ff    <= '0;
         enable_ff   <= '1;
         gate_ff     <= '0;
         for (int c = 0; c < SLOTS; c++) begin
            power_ff[c]  <= '0;
            target_ff[c] <= '0;
            speed_ff[c]  <= '0;
            accel_ff[c]  <= '0;
         end
      end else if (fire) begin
         pwm_ff      <= pwm_in;
         prescale_ff <= prescale_in;
         pos_ff      <= pos_in;
         moved_ff    <= moved_in;
         timer_ff    <= timer_in;
         saved_ff    <= saved_in;
         enable_ff   <= enable_in;
         gate_ff     <= gate_in;
         for (int c = 0; c < SLOTS; c++) begin
            power_ff[c]  <= power_in[c];
            target_ff[c] <= target_in[c];
            speed_ff[c]  <= speed_in[c];
            accel_ff[c]  <= accel_in[c];
         end
      end
   end

   // slot one stays zero when only one channel is built
   always_comb begin
      result.gate_one     = gate_in[0];
      result.gate_two     = gate_in[1];
      result.adc_start    = start;
      result.adc_channel  = start & ch[0];
      result.measured_one = speed_in[0];
      result.measured_two = speed_in[1];
      result.drive_one    = power_in[0];
      result.drive_two    = power_in[1];
   end

endmodule

`default_nettype wire

### rtl/bpsc_checker.sv
`default_nettype none

module bpsc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire bpsc_pkg::rsp_type rsp_data
);
   import bpsc_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // power never exceeds the full-speed cap on either channel
   a_drive_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.drive_one <= CAP_FULL && rsp_data.drive_two <= CAP_FULL)
      else $error("drive level above cap");

   a_channel_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.adc_start |-> !rsp_data.adc_channel)
      else $error("adc channel set without a start");

   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.measured_one <= SPEED_MAX && rsp_data.measured_two <= SPEED_MAX)
      else $error("filtered speed out of range");

endmodule

bind backemf_pwm_speed_controller_core bpsc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### sim/backemf_pwm_speed_controller_checker.sv
`timescale 1ns / 1ps

module backemf_pwm_speed_controller_checker
   import bpsc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_ready,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data,
   input  wire logic    csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output int           fail_count,
   output int           pending,
   output int           readings
);

   localparam int CH        = CHANNELS_DEFAULT;
   localparam int PAUSE_POS = 4 * CH;

   cfg_type          cfg;
   logic [6:0]       pwm_count;
   logic [7:0]       tick_div;
   logic [POS_W-1:0] seq_pos;
   logic             seq_moved;
   logic [15:0]      step_count;
   int               held_power;
   logic             gate_on [CH];
   logic             gate_out [CH];
   int               power [CH];
   int               target [CH];
   int               speed [CH];
   int               accel [CH];
   rsp_type          due_status [$];

   function automatic int clip_byte(input int v);
      if (v > 127) return 127;
      if (v < -128) return -128;
      return v;
   endfunction

   function automatic int next_power(input int pw, input int sp, input int tg, input int ac);
      int cap;
      int d;
      if (tg == 0) return 0;
      cap = (sp >= int'(CAP_KNEE)) ? int'(CAP_FULL) : int'(CAP_BASE) + 4 * sp;
      d = clip_byte(tg - sp);
      // step toward target only while acceleration is not already covering it
      if (d > 0) begin
         if (ac <= d / 4) pw = pw + d / 4 + 1;
      end else if (ac >= d / 4) begin
         pw = pw + d / 4 - 1;
      end
      if (pw > cap) pw = cap;
      if (pw > 100) pw = 100;
      if (pw < 0) pw = 0;
      return pw;
   endfunction

   task automatic init_model();
      cfg.pwm_step        = PWM_STEP_RESET;
      cfg.postscale_count = POSTSCALE_RESET;
      cfg.settle_steps    = SETTLE_RESET;
      cfg.pause_steps     = PAUSE_RESET;
      pwm_count  = '0;
      tick_div   = '0;
      seq_pos    = '0;
      seq_moved  = 1'b1;
      step_count = '0;
      held_power = 0;
      for (int c = 0; c < CH; c++) begin
         gate_on[c]  = 1'b1;
         gate_out[c] = 1'b0;
         power[c]    = 0;
         target[c]   = 0;
         speed[c]    = 0;
         accel[c]    = 0;
      end
      readings = 0;
   endtask

   task automatic take_reading(input int ch, input logic [6:0] raw);
      int emf_speed;
      int quad;
      if (raw < 7'd2) emf_speed = 100;
      else if (raw > 7'd100) emf_speed = 0;
      else emf_speed = 100 - int'(raw);
      // quad holds four times the new estimate, so acceleration sees exact quarters
      quad = 3 * speed[ch] + emf_speed;
      accel[ch] = clip_byte((12 * accel[ch] + (quad - 4 * speed[ch]) * 10) / 16);
      speed[ch] = quad / 4;
      power[ch] = next_power(held_power, speed[ch], target[ch], accel[ch]);
      gate_on[ch] = 1'b1;
      readings++;
   endtask

   task automatic advance_controller(input req_type t, output rsp_type y);
      int               nxt;
      int               ch;
      logic [POS_W-1:0] old_pos;
      logic             start;
      logic             start_ch;
      start    = 1'b0;
      start_ch = 1'b0;
      if (t.opcode == OP_STOP) begin
         for (int c = 0; c < CH; c++) begin
            target[c] = 0;
            power[c]  = 0;
         end
      end else if (t.opcode == OP_SET_ONE) begin
         target[0] = int'($signed(t.speed_arg));
      end else if (t.opcode == OP_SET_TWO) begin
         target[1] = int'($signed(t.speed_arg));
      end

      nxt = int'(pwm_count) + int'(cfg.pwm_step);
      pwm_count = (nxt > int'(PWM_TOP)) ? 7'd0 : 7'(nxt);
      for (int c = 0; c < CH; c++)
         if (gate_on[c]) gate_out[c] = (int'(pwm_count) < power[c]);

      tick_div = tick_div + 8'd1;
      if (tick_div == cfg.postscale_count) begin
         old_pos  = seq_pos;
         tick_div = '0;
         if (int'(seq_pos) > PAUSE_POS) begin
            seq_pos = '0;
         end else if (int'(seq_pos) == PAUSE_POS) begin
            if (seq_moved) step_count = '0;
            step_count = step_count + 16'd1;
            if (step_count >= cfg.pause_steps) seq_pos = '0;
         end else begin
            ch = int'(seq_pos) / 4;
            case (seq_pos[1:0])
               PH_HALT: begin
                  held_power   = power[ch];
                  gate_on[ch]  = 1'b0;
                  power[ch]    = 0;
                  gate_out[ch] = 1'b0;
                  seq_pos      = seq_pos + POS_W'(1);
               end
               PH_WAIT: begin
                  if (seq_moved) step_count = '0;
                  step_count = step_count + 16'd1;
                  if (step_count > {8'd0, cfg.settle_steps}) seq_pos = seq_pos + POS_W'(1);
               end
               PH_START: begin
                  start    = 1'b1;
                  start_ch = ch[0];
                  seq_pos  = seq_pos + POS_W'(1);
               end
               default: begin
                  // hold in measure until the conversion reports done
                  if (t.adc_done) begin
                     take_reading(ch, t.adc_value);
                     seq_pos = seq_pos + POS_W'(1);
                  end
               end
            endcase
         end
         seq_moved = (seq_pos != old_pos);
      end

      y.gate_one     = gate_out[0];
      y.gate_two     = gate_out[1];
      y.adc_start    = start;
      y.adc_channel  = start_ch;
      y.measured_one = 7'(speed[0]);
      y.measured_two = 7'(speed[1]);
      y.drive_one    = 7'(power[0]);
      y.drive_two    = 7'(power[1]);
   endtask

   task automatic check_field(input string name, input logic [6:0] want, input logic [6:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         init_model();
         due_status.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_status.size() == 0) begin
               $display("%0t: status beat with nothing pending, expected none, got %h",
                        $time, rsp_data);
               fail_count++;
            end else begin
               want = due_status.pop_front();
               check_field("gate_one", {6'd0, want.gate_one}, {6'd0, rsp_data.gate_one});
               check_field("gate_two", {6'd0, want.gate_two}, {6'd0, rsp_data.gate_two});
               check_field("adc_start", {6'd0, want.adc_start}, {6'd0, rsp_data.adc_start});
               check_field("adc_channel", {6'd0, want.adc_channel},
                           {6'd0, rsp_data.adc_channel});
               check_field("measured_one", want.measured_one, rsp_data.measured_one);
               check_field("measured_two", want.measured_two, rsp_data.measured_two);
               check_field("drive_one", want.drive_one, rsp_data.drive_one);
               check_field("drive_two", want.drive_two, rsp_data.drive_two);
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_PWM_STEP:  cfg.pwm_step        = csr_wdata[6:0];
               CSR_POSTSCALE: cfg.postscale_count = csr_wdata[7:0];
               CSR_SETTLE:    cfg.settle_steps    = csr_wdata[7:0];
               default:       cfg.pause_steps     = csr_wdata;
            endcase
         end
         if (req_valid && req_ready) begin
            advance_controller(req_data, want);
            due_status.push_back(want);
         end
      end
      pending = due_status.size();
   end

endmodule

### sim/backemf_pwm_speed_controller_core_test.sv
`timescale 1ns / 1ps

module backemf_pwm_speed_controller_core_test;
   import bpsc_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_valid  = 1'b0;
   logic        req_ready;
   req_type     req_data   = '0;
   logic        rsp_valid;
   logic        rsp_ready  = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = CSR_PWM_STEP;
   logic [15:0] csr_wdata  = '0;

   int fail_count;
   int pending;
   int readings;
   int beats_sent       = 0;
   int settings_written = 0;
   int burst_left       = 0;
   int idle_cycles      = 0;
   int stall_mode       = 0;
   int stall_span       = 0;

   backemf_pwm_speed_controller_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   backemf_pwm_speed_controller_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .readings   (readings)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver: switch among four stall styles, each held for a random span
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_span <= $urandom_range(20, 200);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 1) == 0);
         2:       rsp_ready <= (stall_span[1:0] != 2'd0);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type tick_item(input logic [1:0] op, input logic [7:0] arg,
                                         input logic done, input logic [6:0] raw);
      req_type t;
      t.opcode    = op;
      t.speed_arg = arg;
      t.adc_done  = done;
      t.adc_value = raw;
      return t;
   endfunction

   function automatic req_type random_tick();
      logic [31:0] bits;
      int          pick;
      logic [1:0]  op;
      logic [7:0]  arg;
      logic [6:0]  raw;
      bits = $urandom;
      if (bits[31:27] == 5'd0) return tick_item(bits[1:0], bits[9:2], bits[10], bits[17:11]);
      pick = $urandom_range(0, 99);
      if (pick < 3) op = OP_STOP;
      else if (pick < 18) op = OP_SET_ONE;
      else if (pick < 33) op = OP_SET_TWO;
      else op = OP_NONE;
      if ($urandom_range(0, 9) < 8) arg = 8'($urandom_range(1, 100));
      else arg = bits[25:18];
      if ($urandom_range(0, 6) != 0) raw = 7'($urandom_range(0, 100));
      else raw = 7'($urandom_range(101, 127));
      return tick_item(op, arg, $urandom_range(0, 4) != 0, raw);
   endfunction

   task automatic send_beat(input req_type t);
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 30)) @(posedge clock);
         else repeat ($urandom_range(1, 6)) @(posedge clock);
         // now and then hold off until every status beat is back
         if ($urandom_range(0, 24) == 0) while (pending != 0) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(0, 20);
      end
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic apply_setting(input int step, input int post, input int settle,
                                input int pause_len);
      csr_we    <= 1'b1;
      csr_index <= CSR_PWM_STEP;
      csr_wdata <= 16'(step);
      @(posedge clock);
      csr_index <= CSR_POSTSCALE;
      csr_wdata <= 16'(post);
      @(posedge clock);
      csr_index <= CSR_SETTLE;
      csr_wdata <= 16'(settle);
      @(posedge clock);
      csr_index <= CSR_PAUSE;
      csr_wdata <= 16'(pause_len);
      @(posedge clock);
      csr_we <= 1'b0;
      settings_written++;
   endtask

   task automatic run_random(input int count);
      for (int k = 0; k < count; k++) begin
         send_beat(random_tick());
         pace();
      end
      quiesce();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults straight out of reset
      send_beat(tick_item(OP_NONE, 8'h00, 1'b0, 7'd0));
      send_beat(tick_item(OP_SET_ONE, 8'h7F, 1'b1, 7'd127));
      send_beat(tick_item(OP_SET_TWO, 8'h80, 1'b1, 7'd100));
      quiesce();

      // postscale 4 lines up with the divider, one beat takes the halt step
      apply_setting(1, 4, 0, 0);
      send_beat(tick_item(OP_SET_TWO, 8'd50, 1'b0, 7'd0));
      quiesce();

      // one sequencer step per tick, zero settle and zero pause
      apply_setting(100, 1, 0, 0);
      send_beat(tick_item(OP_NONE, 8'h00, 1'b1, 7'd1));
      send_beat(tick_item(OP_NONE, 8'h00, 1'b0, 7'd0));
      send_beat(tick_item(OP_NONE, 8'hFF, 1'b0, 7'd55));
      send_beat(tick_item(OP_NONE, 8'h00, 1'b1, 7'd0));
      send_beat(tick_item(OP_NONE, 8'h00, 1'b1, 7'd0));
      send_beat(tick_item(OP_NONE, 8'h00, 1'b1, 7'd0));
      send_beat(tick_item(OP_NONE, 8'h00, 1'b1, 7'd0));
      send_beat(tick_item(OP_NONE, 8'h00, 1'b1, 7'd101));
      send_beat(tick_item(OP_NONE, 8'h00, 1'b1, 7'd0));
      send_beat(tick_item(OP_SET_ONE, 8'd90, 1'b1, 7'd0));
      send_beat(tick_item(OP_NONE, 8'h00, 1'b1, 7'd0));
      send_beat(tick_item(OP_NONE, 8'h00, 1'b1, 7'd0));
      send_beat(tick_item(OP_NONE, 8'h00, 1'b1, 7'd2));
      send_beat(tick_item(OP_NONE, 8'h00, 1'b1, 7'd0));
      send_beat(tick_item(OP_SET_ONE, 8'h80, 1'b1, 7'd0));
      send_beat(tick_item(OP_NONE, 8'h00, 1'b1, 7'd0));
      send_beat(tick_item(OP_NONE, 8'h00, 1'b1, 7'd127));
      send_beat(tick_item(OP_STOP, 8'h00, 1'b1, 7'd100));
      send_beat(tick_item(OP_SET_TWO, 8'h00, 1'b1, 7'd0));
      send_beat(tick_item(OP_NONE, 8'h00, 1'b1, 7'd0));
      quiesce();

      apply_setting(1, 1, 0, 1);
      run_random(100);
      apply_setting(100, 2, 2, 3);
      run_random(100);
      // long settle: one full wait of 256 steps
      apply_setting(37, 1, 255, 2);
      run_random(300);
      // park in a pause that outlasts the phase
      apply_setting(5, 1, 0, 65535);
      run_random(120);
      // divider wraps: one step per 256 ticks
      apply_setting(13, 0, 1, 0);
      run_random(260);
      apply_setting(9, 5, 1, 5);
      run_random(150);
      apply_setting(64, 255, 0, 1);
      run_random(150);

      repeat (4) @(posedge clock);
      $display("covered %0d tick beats under %0d register settings, %0d back-EMF readings",
               beats_sent, settings_written, readings);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
